// File: hdl/assert_macros.svh
// Assertion macros for the checker file drvu_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skipped while reset is low.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/drvu_pkg.sv
// Types, constants and codes of the distance vector route update block.
// No dependencies.
package drvu_pkg;

    localparam int NODE_COUNT = 256;
    localparam int COST_WIDTH = 32;
    localparam int IDX_W      = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

    typedef logic [COST_WIDTH-1:0] t_cost;
    typedef logic [IDX_W-1:0]      t_idx;

    localparam t_cost COST_UNREACH = t_cost'(1);
    localparam t_cost COST_MAX     = '1;

    typedef enum logic [1:0] {
        REQ_VECTOR = 2'd0,
        REQ_SET    = 2'd1,
        REQ_LOOKUP = 2'd2,
        REQ_SPARE  = 2'd3
    } t_req_type;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  neighbor_id;
        logic [7:0]  dest_id;
        logic [31:0] cost_value;
    } t_in_item;

    typedef struct packed {
        logic [31:0] route_cost;
        logic [7:0]  next_hop;
        logic        reachable;
        logic        advert_valid;
    } t_out_item;

    typedef struct packed {
        t_cost      cost;
        logic [7:0] hop;
    } t_entry;

    localparam t_entry ENTRY_RESET = '{cost: COST_UNREACH, hop: 8'd0};

    typedef struct packed {
        logic en;
        t_idx nb_idx;
        t_idx dst_idx;
    } t_rd_req;

    typedef struct packed {
        logic   en;
        t_idx   idx;
        t_entry data;
    } t_wr_req;

    typedef struct packed {
        t_entry nb;
        t_entry dst;
    } t_rd_data;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

endpackage

// File: hdl/drvu_table.sv
// Route table memory: one entry (cost, next hop) per destination.
// Two registered read ports, one write port, valid bits for reset. Uses drvu_pkg.
module drvu_table import drvu_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_rd_req  i_rd,
    input  t_wr_req  i_wr,
    output t_rd_data o_rd
);

    t_entry                r_mem [NODE_COUNT];
    logic [NODE_COUNT-1:0] r_valid;
    t_entry                r_nb_data;
    t_entry                r_dst_data;
    logic                  r_nb_vld;
    logic                  r_dst_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.idx] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_nb_data  <= r_mem[i_rd.nb_idx];
            r_dst_data <= r_mem[i_rd.dst_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_nb_vld  <= 1'b0;
            r_dst_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.idx] <= 1'b1;
            end
            if (i_rd.en) begin
                r_nb_vld  <= r_valid[i_rd.nb_idx];
                r_dst_vld <= r_valid[i_rd.dst_idx];
            end
        end
    end

    assign o_rd.nb  = r_nb_vld  ? r_nb_data  : ENTRY_RESET;
    assign o_rd.dst = r_dst_vld ? r_dst_data : ENTRY_RESET;

endmodule

// File: hdl/drvu_calc.sv
// Update rule for one item: fill, relax, tie break, cost set, lookup.
// Produces the write back and the result item. Uses drvu_pkg.
module drvu_calc import drvu_pkg::*; (
    input  t_in_item  i_item,
    input  t_rd_data  i_rd,
    output t_wr_req   o_wr,
    output t_out_item o_result
);

    logic          nb_ok;
    logic          dst_ok;
    logic          req_ok;
    t_cost         val;
    logic [COST_WIDTH:0] sum;
    t_cost         total;
    t_cost         cost;
    logic [7:0]    hop;
    logic          adv;
    logic          wen;

    always_comb begin
        nb_ok  = (32'(i_item.neighbor_id) < 32'(NODE_COUNT));
        dst_ok = (32'(i_item.dest_id) < 32'(NODE_COUNT));
        req_ok = dst_ok && (nb_ok || (i_item.req_type != REQ_VECTOR));
        val    = t_cost'(i_item.cost_value);
        sum    = {1'b0, val} + {1'b0, i_rd.nb.cost};
        total  = sum[COST_WIDTH] ? COST_MAX : sum[COST_WIDTH-1:0];
        cost   = i_rd.dst.cost;
        hop    = i_rd.dst.hop;
        adv    = 1'b0;
        wen    = 1'b0;

        case (i_item.req_type)
            REQ_VECTOR: begin
                if ((i_item.dest_id != i_item.neighbor_id) && (val != COST_UNREACH)) begin
                    wen = 1'b1;
                    if (cost == COST_UNREACH) begin
                        cost = total;
                        hop  = (i_rd.nb.hop != i_item.neighbor_id) ? i_rd.nb.hop
                                                                   : i_item.neighbor_id;
                        adv  = 1'b1;
                    end
                    if (cost > total) begin
                        cost = total;
                        hop  = i_item.neighbor_id;
                        adv  = 1'b1;
                    end
                    if ((cost == total) && (hop > i_item.neighbor_id)) begin
                        hop = i_item.neighbor_id;
                    end
                end
            end
            REQ_SET: begin
                wen  = 1'b1;
                cost = val;
            end
            default: begin
            end
        endcase

        o_wr.en   = wen && req_ok;
        o_wr.idx  = t_idx'(i_item.dest_id);
        o_wr.data = '{cost: cost, hop: hop};

        if (req_ok) begin
            o_result.route_cost   = 32'(cost);
            o_result.next_hop     = hop;
            o_result.reachable    = (cost != COST_UNREACH);
            o_result.advert_valid = adv;
        end else begin
            o_result.route_cost   = 32'(COST_UNREACH);
            o_result.next_hop     = 8'd0;
            o_result.reachable    = 1'b0;
            o_result.advert_valid = 1'b0;
        end
    end

endmodule

// File: hdl/distance_vector_route_update.sv
// Top level of the distance vector route update block.
// Instantiates drvu_table and drvu_calc. Uses drvu_pkg.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+---------------------
//   request  | i_in_valid / o_in_ready  | i_in_item  (t_in_item)
//   result   | o_out_valid / i_out_ready| o_out_item (t_out_item)
//
// For each item, the accept edge issues both table reads; the edge that leaves
// execute writes back and loads the result register (single write port).
// Reset is synchronous; valid bits make every entry read as cost 1, hop 0.
// A full result register that is not taken holds the item in execute.
// The next item is accepted while a result waits to be taken.
module distance_vector_route_update import drvu_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_state    r_state;
    t_state    n_state;
    t_in_item  r_req;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      accept;
    logic      load;
    t_rd_req   rd;
    t_wr_req   calc_wr;
    t_wr_req   wr;
    t_rd_data  rd_data;
    t_out_item result;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        load       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!r_out_valid || i_out_ready) begin
                    load    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign accept     = i_in_valid && o_in_ready;
    assign rd.en      = accept;
    assign rd.nb_idx  = t_idx'(i_in_item.neighbor_id);
    assign rd.dst_idx = t_idx'(i_in_item.dest_id);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_in_item;
        end
        if (load) begin
            r_out_item <= result;
        end
    end

    drvu_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (rd),
        .i_wr    (wr),
        .o_rd    (rd_data)
    );

    drvu_calc u_calc (
        .i_item   (r_req),
        .i_rd     (rd_data),
        .o_wr     (calc_wr),
        .o_result (result)
    );

    always_comb begin
        wr    = calc_wr;
        wr.en = calc_wr.en && load;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// File: hdl/drvu_checker.sv
// Port level checks of the route update block, bound to the top level.
// Uses drvu_pkg and assert_macros.svh.
`include "assert_macros.svh"

module drvu_checker import drvu_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    logic in_acc;
    logic out_stall;
    logic reach_ok;

    assign in_acc    = i_in_valid && o_in_ready;
    assign out_stall = o_out_valid && !i_out_ready;
    assign reach_ok  = (o_out_item.reachable == (o_out_item.route_cost != 32'(COST_UNREACH)));

    `ASSERT_RST(a_out_hold, i_clk, i_rst_n, out_stall |=> o_out_valid, "stalled item dropped")
    `ASSERT_RST(a_out_stable, i_clk, i_rst_n, out_stall |=> $stable(o_out_item), "stalled item changed")
    `ASSERT_RST(a_reach, i_clk, i_rst_n, o_out_valid |-> reach_ok, "reachable disagrees with cost")
    `ASSERT_RST(a_one_at_a_time, i_clk, i_rst_n, in_acc |=> !o_in_ready, "item accepted while busy")

endmodule

bind distance_vector_route_update drvu_checker u_drvu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

// File: bench/drvu_route_checker.sv
// Route table checker: watches both channels, predicts each result item from a
// shadow cost and hop table, and compares it with what the block returns.
// Depends on drvu_pkg for item types and request codes.
module drvu_route_checker import drvu_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_item,
    output int        o_fail_count,
    output int        o_backlog
);

    t_cost      cost_shadow [NODE_COUNT];
    logic [7:0] hop_shadow  [NODE_COUNT];
    t_out_item  expected_routes [$];
    t_out_item  head_route;
    int         fail_total;
    int         backlog_count;

    assign o_fail_count = fail_total;
    assign o_backlog    = backlog_count;

    function automatic t_out_item predict_route(input t_in_item req);
        t_out_item              res;
        logic [7:0]             nb;
        logic [7:0]             dst;
        t_cost                  offered;
        t_cost                  total;
        logic [COST_WIDTH:0]    wide_sum;
        logic                   adv;
        res     = '0;
        adv     = 1'b0;
        nb      = req.neighbor_id;
        dst     = req.dest_id;
        offered = req.cost_value[COST_WIDTH-1:0];
        if (dst >= NODE_COUNT || (req.req_type == REQ_VECTOR && nb >= NODE_COUNT)) begin
            res.route_cost = 32'(COST_UNREACH);
            return res;
        end
        case (req.req_type)
            REQ_VECTOR: begin
                if (dst != nb && offered != COST_UNREACH) begin
                    wide_sum = {1'b0, offered} + {1'b0, cost_shadow[nb]};
                    total    = wide_sum[COST_WIDTH] ? COST_MAX : wide_sum[COST_WIDTH-1:0];
                    if (cost_shadow[dst] == COST_UNREACH) begin
                        cost_shadow[dst] = total;
                        hop_shadow[dst]  = (hop_shadow[nb] != nb) ? hop_shadow[nb] : nb;
                        adv              = 1'b1;
                    end
                    if (cost_shadow[dst] > total) begin
                        cost_shadow[dst] = total;
                        hop_shadow[dst]  = nb;
                        adv              = 1'b1;
                    end
                    if (cost_shadow[dst] == total && hop_shadow[dst] > nb) begin
                        hop_shadow[dst] = nb;
                    end
                end
            end
            REQ_SET: begin
                cost_shadow[dst] = offered;
            end
            default: ;
        endcase
        res.route_cost   = 32'(cost_shadow[dst]);
        res.next_hop     = hop_shadow[dst];
        res.reachable    = (cost_shadow[dst] != COST_UNREACH);
        res.advert_valid = adv;
        return res;
    endfunction

    initial begin
        fail_total    = 0;
        backlog_count = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < NODE_COUNT; n++) begin
                cost_shadow[n] = COST_UNREACH;
                hop_shadow[n]  = 8'd0;
            end
            expected_routes.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_routes.size() == 0) begin
                    $error("result item with none expected: %p", i_out_item);
                    fail_total++;
                end else begin
                    head_route = expected_routes.pop_front();
                    if (i_out_item.route_cost !== head_route.route_cost) begin
                        $error("route_cost: expected %0h, got %0h",
                               head_route.route_cost, i_out_item.route_cost);
                        fail_total++;
                    end
                    if (i_out_item.next_hop !== head_route.next_hop) begin
                        $error("next_hop: expected %0d, got %0d",
                               head_route.next_hop, i_out_item.next_hop);
                        fail_total++;
                    end
                    if (i_out_item.reachable !== head_route.reachable) begin
                        $error("reachable: expected %0b, got %0b",
                               head_route.reachable, i_out_item.reachable);
                        fail_total++;
                    end
                    if (i_out_item.advert_valid !== head_route.advert_valid) begin
                        $error("advert_valid: expected %0b, got %0b",
                               head_route.advert_valid, i_out_item.advert_valid);
                        fail_total++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_routes.push_back(predict_route(i_in_item));
            end
        end
        backlog_count = expected_routes.size();
    end

endmodule

// File: bench/testbench.sv
// Top of the route table bench: clock, reset, request stimulus, result stalls,
// watchdog and verdict. Depends on drvu_pkg, distance_vector_route_update and
// drvu_route_checker.
module testbench;
    import drvu_pkg::*;

    localparam int RANDOM_REQS  = 450;
    localparam int CALM_TAIL    = 60;
    localparam int STALL_LIMIT  = 2000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    int        fail_count;
    int        backlog;
    int        quiet_cycles;
    bit        idle_off;
    t_in_item  directed_reqs [$];

    distance_vector_route_update i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    drvu_route_checker i_route_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_item   (o_out_item),
        .o_fail_count (fail_count),
        .o_backlog    (backlog)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_in_item route_req(input t_req_type kind, input logic [7:0] nb,
                                           input logic [7:0] dst, input logic [31:0] cost);
        t_in_item req;
        req.req_type    = kind;
        req.neighbor_id = nb;
        req.dest_id     = dst;
        req.cost_value  = cost;
        return req;
    endfunction

    function automatic t_in_item random_route_req();
        t_in_item   req;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)      req.req_type = REQ_VECTOR;
        else if (pick < 75) req.req_type = REQ_SET;
        else if (pick < 95) req.req_type = REQ_LOOKUP;
        else                req.req_type = REQ_SPARE;
        // keep most ids in a small cluster so routes interact
        if ($urandom_range(0, 4) == 0) begin
            req.neighbor_id = 8'($urandom_range(0, 255));
            req.dest_id     = 8'($urandom_range(0, 255));
        end else begin
            req.neighbor_id = 8'($urandom_range(0, 15));
            req.dest_id     = 8'($urandom_range(0, 15));
        end
        if ($urandom_range(0, 11) == 0) req.dest_id = req.neighbor_id;
        case ($urandom_range(0, 9))
            0:       req.cost_value = 32'd1;
            1:       req.cost_value = $urandom();
            2:       req.cost_value = 32'hFFFF_FFFF - $urandom_range(0, 15);
            3:       req.cost_value = 32'd0;
            default: req.cost_value = $urandom_range(0, 40);
        endcase
        return req;
    endfunction

    task automatic send_route_req(input t_in_item req, input bit may_idle);
        int gap;
        gap = (may_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item  <= req;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    initial begin
        int  span;
        bit  stall;
        i_out_ready = 1'b0;
        forever begin
            if (idle_off) begin
                stall = 1'b0;
                span  = 1;
            end else if ($urandom_range(0, 3) == 0) begin
                stall = 1'b1;
                span  = $urandom_range(1, 7);
            end else begin
                stall = 1'b0;
                span  = $urandom_range(1, 10);
            end
            repeat (span) begin
                @(negedge i_clk);
                i_out_ready <= !stall;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("distance_vector_route_update test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        idle_off   = 1'b0;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_item  = '0;

        directed_reqs.push_back(route_req(REQ_LOOKUP, 8'd0,   8'd0,   32'd0));
        directed_reqs.push_back(route_req(REQ_LOOKUP, 8'd255, 8'd255, 32'hFFFF_FFFF));
        directed_reqs.push_back(route_req(REQ_SPARE,  8'd9,   8'd7,   32'd5));
        directed_reqs.push_back(route_req(REQ_SET,    8'd0,   8'd10,  32'd3));
        directed_reqs.push_back(route_req(REQ_VECTOR, 8'd10,  8'd20,  32'd4));
        directed_reqs.push_back(route_req(REQ_VECTOR, 8'd10,  8'd10,  32'd2));
        directed_reqs.push_back(route_req(REQ_VECTOR, 8'd11,  8'd20,  32'd1));
        directed_reqs.push_back(route_req(REQ_VECTOR, 8'd5,   8'd20,  32'd2));
        directed_reqs.push_back(route_req(REQ_VECTOR, 8'd3,   8'd20,  32'd2));
        directed_reqs.push_back(route_req(REQ_VECTOR, 8'd4,   8'd20,  32'd2));
        directed_reqs.push_back(route_req(REQ_SET,    8'd0,   8'd30,  32'hFFFF_FFF0));
        directed_reqs.push_back(route_req(REQ_VECTOR, 8'd30,  8'd40,  32'hFFFF_FFFF));
        directed_reqs.push_back(route_req(REQ_VECTOR, 8'd30,  8'd40,  32'd0));
        directed_reqs.push_back(route_req(REQ_SET,    8'd0,   8'd50,  32'd0));
        directed_reqs.push_back(route_req(REQ_VECTOR, 8'd0,   8'd5,   32'd6));
        directed_reqs.push_back(route_req(REQ_VECTOR, 8'd5,   8'd70,  32'd2));
        directed_reqs.push_back(route_req(REQ_VECTOR, 8'd255, 8'd0,   32'hFFFF_FFFF));
        directed_reqs.push_back(route_req(REQ_SET,    8'd0,   8'd255, 32'hFFFF_FFFF));
        directed_reqs.push_back(route_req(REQ_VECTOR, 8'd255, 8'd0,   32'd0));
        directed_reqs.push_back(route_req(REQ_SET,    8'd0,   8'd20,  32'd1));
        directed_reqs.push_back(route_req(REQ_LOOKUP, 8'd0,   8'd20,  32'd0));
        directed_reqs.push_back(route_req(REQ_VECTOR, 8'd50,  8'd20,  32'd2));
        directed_reqs.push_back(route_req(REQ_LOOKUP, 8'd0,   8'd70,  32'd0));

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_reqs[k]) send_route_req(directed_reqs[k], 1'b1);
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n == RANDOM_REQS - CALM_TAIL) idle_off = 1'b1;
            send_route_req(random_route_req(), !idle_off);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        while (backlog != 0) @(negedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("distance_vector_route_update test passed");
        end else begin
            $display("distance_vector_route_update test failed");
        end
        $finish;
    end

endmodule
